[hdl/ftp_reply_parser_assert.svh]
// Assertion macros for the control-channel reply parser.
// Used by the top level; the macros reference the clk and rst_n ports.
`ifndef FTP_REPLY_PARSER_ASSERT_SVH
`define FTP_REPLY_PARSER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication under reset
`define FTPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication under reset
`define FTPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FTPR_ASSERT_IMP(lbl, ante, cons, msg)
`define FTPR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/ftpr_pkg.sv]
// Shared constants, types and helper functions of the reply parser.
// No dependencies; imported by every module of the block.
package ftpr_pkg;

  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_DASH  = 8'h2D;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [15:0] MAX_LEN_RST = 16'd4096;
  localparam logic [15:0] HEAD_LEN    = 16'd4;

  // Line event handed from the line tracker to the reply logic
  typedef struct packed {
    logic       eol;      // LF taken this cycle
    logic       ovf;      // line reached the length limit
    logic       counted;  // long enough, no zero byte in the head, starts with a digit
    logic       three;    // columns two and three are digits
    logic       dash;     // column four is a dash
    logic       space;    // column four is a space
    logic [9:0] code;     // three-digit code of the line head
  } line_evt_t;

  // Result produced by the reply logic
  typedef struct packed {
    logic       valid;
    logic [9:0] code;
    logic       status;
    logic       multi;
  } reply_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [9:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    digit_val = {6'b0, d[3:0]};
  endfunction

endpackage

[hdl/ftpr_line.sv]
// Line tracker: position counter, four-byte line head, CR and zero-byte flags.
// Depends on ftpr_pkg; emits one line_evt_t per advanced byte.
module ftpr_line import ftpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] max_len,
  output line_evt_t   evt
);

  logic [15:0] pos_r;
  logic        zero_r;
  logic        cr_r;
  logic [7:0]  head_r [4];

  logic        is_lf;
  logic        ovf;
  logic        in_head;
  logic        eff_ok;
  logic [16:0] pos_inc;

  // Decode the incoming byte against the held line
  always_comb begin
    is_lf   = (rx_byte == CH_LF);
    pos_inc = {1'b0, pos_r} + 17'd1;
    ovf     = !is_lf && (pos_inc >= {1'b0, max_len});
    in_head = (pos_r < HEAD_LEN);
    eff_ok  = (pos_r > HEAD_LEN) || ((pos_r == HEAD_LEN) && !cr_r);

    evt.eol     = adv && is_lf;
    evt.ovf     = adv && ovf;
    evt.counted = !zero_r && eff_ok && is_digit(head_r[0]);
    evt.three   = is_digit(head_r[1]) && is_digit(head_r[2]);
    evt.dash    = (head_r[3] == CH_DASH);
    evt.space   = (head_r[3] == CH_SPACE);
    evt.code    = 10'(digit_val(head_r[0]) * 10'd100)
                + 10'(digit_val(head_r[1]) * 10'd10)
                + digit_val(head_r[2]);
  end

  // Advance the position and flags; clear at LF or overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      zero_r <= 1'b0;
      cr_r   <= 1'b0;
    end else if (adv) begin
      if (is_lf || ovf) begin
        pos_r  <= '0;
        zero_r <= 1'b0;
        cr_r   <= 1'b0;
      end else begin
        pos_r  <= pos_inc[15:0];
        zero_r <= zero_r || (in_head && (rx_byte == 8'h00));
        cr_r   <= (rx_byte == CH_CR);
      end
    end
  end

  // Capture the first four bytes of the line
  always_ff @(posedge clk) begin
    if (adv && !is_lf && in_head) begin
      head_r[pos_r[1:0]] <= rx_byte;
    end
  end

endmodule

[hdl/ftpr_reply.sv]
// Reply tracker: open multi-line reply state and result selection.
// Depends on ftpr_pkg; consumes line_evt_t from ftpr_line.
module ftpr_reply import ftpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  line_evt_t  evt,
  output reply_res_t res
);

  logic       in_reply_r, in_reply_nxt;
  logic [9:0] held_r, held_nxt;

  // Decide the result and the next reply state
  always_comb begin
    res          = '0;
    in_reply_nxt = in_reply_r;
    held_nxt     = held_r;
    if (evt.ovf) begin
      res.valid    = 1'b1;
      res.status   = 1'b1;
      in_reply_nxt = 1'b0;
      held_nxt     = '0;
    end else if (evt.eol && evt.counted && evt.three) begin
      if (!in_reply_r) begin
        if (evt.dash) begin
          in_reply_nxt = 1'b1;
          held_nxt     = evt.code;
        end else begin
          res.valid = 1'b1;
          res.code  = evt.code;
        end
      end else if ((evt.code == held_r) && evt.space) begin
        res.valid    = 1'b1;
        res.code     = held_r;
        res.multi    = 1'b1;
        in_reply_nxt = 1'b0;
        held_nxt     = '0;
      end
    end
  end

  // Hold the open reply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_reply_r <= 1'b0;
      held_r     <= '0;
    end else begin
      in_reply_r <= in_reply_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

[hdl/ftp_reply_parser.sv]
// FTP control-channel reply parser, top level.
// Depends on ftpr_pkg, ftpr_line, ftpr_reply and ftp_reply_parser_assert.svh.
//
// Usage:
//   in_*  : one received control-channel byte per word (in_tdata[7:0]).
//   out_* : one word per complete reply or per line overflow. out_tdata[9:0]
//           holds the reply code, out_tuser[0] the status (1 = overflow) and
//           out_tuser[1] whether the reply used continuation lines.
//   cfg_* : cfg_wr_en writes cfg_wr_data as the line length limit; write
//           only while the block is idle.
// Path: an accepted byte waits in the input register until the output is free;
//   its result word is then registered at the output and shows on out_tvalid.
// Throughput: one byte per cycle unless out stalls; each byte takes a single
//   pass of compares and a 16-bit count between the input and output registers.
// Reset (rst_n low, synchronous) empties both registers, closes any open
//   reply, clears the current line and sets the limit to 4096.
// When the receiver stalls, the pending result holds; at most one further
//   byte enters the input register, and in_tready stays low until out drains.
module ftp_reply_parser import ftpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] reply_code, [15:10] zero
  output logic [1:0]  out_tuser,  // [0] status, [1] was_multiline
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

`include "ftp_reply_parser_assert.svh"

  logic        s0_valid_r;
  logic [7:0]  s0_byte_r;
  logic        out_valid_r;
  logic [9:0]  out_code_r;
  logic        out_status_r;
  logic        out_multi_r;
  logic [15:0] max_len_r;

  logic        out_free;
  logic        adv;
  logic        in_acc;
  line_evt_t   evt;
  reply_res_t  res;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s0_valid_r && out_free;
  assign in_tready = !s0_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Hold the line length limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Input register: take a word, drop it once processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_acc) begin
      s0_valid_r <= 1'b1;
    end else if (adv) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_byte_r <= in_tdata;
    end
  end

  ftpr_line u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rx_byte (s0_byte_r),
    .max_len (max_len_r),
    .evt     (evt)
  );

  ftpr_reply u_reply (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (evt),
    .res   (res)
  );

  // Output register: load when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_code_r   <= res.code;
      out_status_r <= res.status;
      out_multi_r  <= res.multi;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_code_r};
  assign out_tuser  = {out_multi_r, out_status_r};

  // Overflow words carry no code and no continuation flag
  `FTPR_ASSERT_IMP(a_ovf_clean, out_valid_r && out_status_r,
    (out_code_r == 10'd0) && !out_multi_r, "overflow word carries data")
  // Reply codes stay three decimal digits
  `FTPR_ASSERT_IMP(a_code_range, out_valid_r && !out_status_r,
    out_code_r <= 10'd999, "reply code out of range")
  // A byte waiting on a stalled output stays in the input register
  `FTPR_ASSERT_NXT(a_s0_hold, s0_valid_r && !adv,
    s0_valid_r && $stable(s0_byte_r), "input word lost under stall")

endmodule
